[sv/alab_pkg.sv]
`default_nettype none
package alab_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOG,
      ST_RING_WR,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_DIV,
      ST_CAL_WR,
      ST_SORT_RD,
      ST_SORT_CMP,
      ST_RANK_RD,
      ST_RANK_GET,
      ST_TICK_NUM,
      ST_TICK_DIV,
      ST_TICK_EASE,
      ST_TICK_OUT
   } state_type;

   localparam logic [2:0] CSR_LEVEL_FLOOR   = 3'd0;
   localparam logic [2:0] CSR_LEVEL_CEILING = 3'd1;
   localparam logic [2:0] CSR_MIN_SPAN      = 3'd2;
   localparam logic [2:0] CSR_EASE_COEFF    = 3'd3;
   localparam logic [2:0] CSR_CEILING_RANK  = 3'd4;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   function automatic logic [8:0] mant_tab(input logic [4:0] k);
      logic [8:0] r;
      begin
         case (k)
            5'd0:  r = 9'd0;
            5'd1:  r = 9'd22;
            5'd2:  r = 9'd44;
            5'd3:  r = 9'd63;
            5'd4:  r = 9'd82;
            5'd5:  r = 9'd100;
            5'd6:  r = 9'd118;
            5'd7:  r = 9'd134;
            5'd8:  r = 9'd150;
            5'd9:  r = 9'd165;
            5'd10: r = 9'd179;
            5'd11: r = 9'd193;
            5'd12: r = 9'd207;
            5'd13: r = 9'd220;
            5'd14: r = 9'd232;
            5'd15: r = 9'd244;
            5'd16: r = 9'd256;
            default: r = 9'd0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

[sv/alab_log2.sv]
`default_nettype none
// combinational log2 in 4.12, registered by the caller
module alab_log2 (
   input  wire logic [15:0] value,
   output logic      [15:0] log_value
);
   logic [15:0] v1, v2, v3, v4, v5;
   logic [16:0] r;
   logic [3:0]  k;
   logic [7:0]  q;
   logic [8:0]  p;
   logic [17:0] terp;

   always_comb begin
      r  = 17'h0c000;
      v1 = value;
      v2 = value;
      v3 = value;
      v4 = value;
      v5 = value;
      if ((value & 16'hf000) != 16'h0) begin
         if ((v1 & 16'hc000) != 16'h0) begin v2 = v1 >> 2; r = r + 17'h2000; end
         else v2 = v1;
         if ((v2 & 16'h2000) != 16'h0) begin v5 = v2 >> 1; r = r + 17'h1000; end
         else v5 = v2;
      end else begin
         if ((v1 & 16'hffc0) == 16'h0) begin v2 = v1 << 6; r = r - 17'h6000; end
         else v2 = v1;
         if ((v2 & 16'hfe00) == 16'h0) begin v3 = v2 << 3; r = r - 17'h3000; end
         else v3 = v2;
         if ((v3 & 16'hf800) == 16'h0) begin v4 = v3 << 2; r = r - 17'h2000; end
         else v4 = v3;
         if ((v4 & 16'hf000) == 16'h0) begin v5 = v4 << 1; r = r - 17'h1000; end
         else v5 = v4;
      end
      k = v5[11:8];
      q = v5[7:0];
      p = 9'd256 - {1'b0, q};
      terp = 18'(alab_pkg::mant_tab({1'b0, k}) * p)
           + 18'(alab_pkg::mant_tab({1'b0, k} + 5'd1) * q) + 18'd8;
      r = r + 17'(terp >> 4);
      log_value = r[15:0];
   end
endmodule
`default_nettype wire

[sv/alab_div.sv]
`default_nettype none
// restoring divider, one quotient bit per cycle
module alab_div #(
   parameter int WIDTH = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  done,
   output logic      [WIDTH-1:0] quotient
);
   localparam int CW = $clog2(WIDTH + 1);
   logic [WIDTH-1:0] quot_ff, quot_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [WIDTH:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quot_ff[WIDTH-1]} - {1'b0, dvs_ff};
         if (!trial[WIDTH]) begin
            rem_in  = trial[WIDTH-1:0];
            quot_in = {quot_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[WIDTH-2:0], quot_ff[WIDTH-1]};
            quot_in = {quot_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

[sv/ambient_light_auto_brightness_unit.sv]
`default_nettype none
// Ambient light auto-brightness. A sample word (tuser = 0) turns the ADC value
// into a 4.12 log2, stores it in a ring memory and recomputes the mean by
// reading every filled entry back, then a bit-serial divide by the fill
// count. The first CAL_DEPTH means go into a calibration memory; when it is
// full, an insertion sort over that memory (one read per step and a write per
// shift, once) picks the entry at ceiling_rank as the range top. A tick word
// (tuser = 1) maps the mean into [level_floor, level_ceiling], eases the level
// accumulator and returns one result word; it may wait on a stall on the result
// side. The time of each word is set by the divide and, for samples, the ring
// read-back. One word is processed at a time; the result register lets the
// next word in while a result waits. Sample words give no result.
module ambient_light_auto_brightness_unit #(
   parameter int AVG_DEPTH = 64,
   parameter int CAL_DEPTH = 256,
   parameter int ADC_BITS  = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // adc_sample[11:0], zero pad
   input  wire logic        req_tuser,  // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // brightness_level[8:0], smoothed_light[24:9],
                                        // calibrated[25], zero pad
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int AW = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int FW = $clog2(AVG_DEPTH + 1);
   localparam int CA = $clog2(CAL_DEPTH);
   localparam int CW = $clog2(CAL_DEPTH + 1);
   localparam int DW = 48;

   // configuration registers
   logic [8:0]  floor_ff, ceil_ff;
   logic [15:0] span_ff, ease_ff;
   logic [7:0]  rank_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= 9'd64;
         ceil_ff  <= 9'd256;
         span_ff  <= 16'd256;
         ease_ff  <= 16'd655;
         rank_ff  <= 8'd213;
      end else if (csr_valid) begin
         case (csr_index)
            alab_pkg::CSR_LEVEL_FLOOR:   floor_ff <= csr_data[8:0];
            alab_pkg::CSR_LEVEL_CEILING: ceil_ff  <= csr_data[8:0];
            alab_pkg::CSR_MIN_SPAN:      span_ff  <= csr_data;
            alab_pkg::CSR_EASE_COEFF:    ease_ff  <= csr_data;
            alab_pkg::CSR_CEILING_RANK:  rank_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // memories
   logic [15:0] avg_mem [AVG_DEPTH];
   logic [15:0] cal_mem [CAL_DEPTH];
   logic [15:0] avg_rd_ff, cal_rd_ff;
   logic        avg_we;
   logic [AW-1:0] avg_wa, avg_ra;
   logic [15:0] avg_wd;
   logic        cal_we;
   logic [CA-1:0] cal_wa, cal_ra;
   logic [15:0] cal_wd;

   always_ff @(posedge clock) begin
      if (avg_we) avg_mem[avg_wa] <= avg_wd;
      avg_rd_ff <= avg_mem[avg_ra];
   end
   always_ff @(posedge clock) begin
      if (cal_we) cal_mem[cal_wa] <= cal_wd;
      cal_rd_ff <= cal_mem[cal_ra];
   end

   // state
   alab_pkg::state_type st_ff, st_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [FW-1:0] fill_ff, fill_in, idx_ff, idx_in;
   logic [15:0]   mean_ff, mean_in, top_ff, top_in, bot_ff, bot_in;
   logic [15:0]   samp_ff, samp_in, key_ff, key_in;
   logic          key_ok_ff, key_ok_in;
   logic [CW-1:0] ccnt_ff, ccnt_in;
   logic [CA-1:0] j_ff, j_in, m_ff, m_in;
   logic [23:0]   sum_ff, sum_in;
   logic [24:0]   acc_ff, acc_in;
   logic          tneg_ff, tneg_in;
   logic [DW-1:0] num_ff, num_in, den_ff, den_in;
   logic [24:0]   goal_ff, goal_in;
   logic          rv_ff, rv_in;
   logic [31:0]   rd_ff, rd_in;
   logic [15:0]   log_v;
   logic          div_start, div_done;
   logic [DW-1:0] div_q;

   alab_log2 u_log (.value(samp_ff), .log_value(log_v));
   // operands taken from the next-value side so a start sees them in the same cycle
   alab_div #(.WIDTH(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(num_in), .divisor(den_in), .done(div_done), .quotient(div_q));

   logic        cal_full;
   logic        take;
   logic [16:0] lo_w, hi_w, sp_w;
   logic [17:0] d_w;
   logic [16:0] msp;
   logic [9:0]  cf;
   logic [7:0]  rk;
   logic [49:0] gw;
   logic [41:0] ea, eb;
   logic [42:0] es;

   assign cal_full   = (ccnt_ff == CW'(CAL_DEPTH));
   assign req_tready = (st_ff == alab_pkg::ST_IDLE);
   assign take       = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   always_comb begin
      st_in = st_ff; wpos_in = wpos_ff; fill_in = fill_ff; idx_in = idx_ff;
      mean_in = mean_ff; top_in = top_ff; bot_in = bot_ff; samp_in = samp_ff;
      key_in = key_ff; key_ok_in = key_ok_ff; ccnt_in = ccnt_ff; j_in = j_ff; m_in = m_ff;
      sum_in = sum_ff; acc_in = acc_ff; tneg_in = tneg_ff; num_in = num_ff;
      den_in = den_ff; goal_in = goal_ff;
      rv_in = rv_ff && !rsp_tready; rd_in = rd_ff;
      avg_we = 1'b0; avg_wa = wpos_ff; avg_wd = log_v; avg_ra = idx_ff[AW-1:0];
      cal_we = 1'b0; cal_wa = ccnt_ff[CA-1:0]; cal_wd = mean_ff; cal_ra = m_ff;
      div_start = 1'b0;
      lo_w = '0; hi_w = '0; sp_w = '0; d_w = '0; msp = '0; cf = '0; rk = '0;
      gw = '0; ea = '0; eb = '0; es = '0;
      case (st_ff)
         alab_pkg::ST_IDLE: begin
            if (take) begin
               if (req_tuser == alab_pkg::OP_TICK) st_in = alab_pkg::ST_TICK_NUM;
               else begin
                  samp_in = 16'(req_tdata[ADC_BITS-1:0]);
                  st_in = alab_pkg::ST_LOG;
               end
            end
         end
         alab_pkg::ST_LOG: st_in = alab_pkg::ST_RING_WR;
         alab_pkg::ST_RING_WR: begin
            avg_we = 1'b1;
            wpos_in = (wpos_ff == AW'(AVG_DEPTH - 1)) ? '0 : wpos_ff + AW'(1);
            if (fill_ff != FW'(AVG_DEPTH)) fill_in = fill_ff + FW'(1);
            idx_in = '0; sum_in = '0;
            st_in = alab_pkg::ST_SUM_RD;
         end
         alab_pkg::ST_SUM_RD: begin
            idx_in = idx_ff + FW'(1);
            st_in = alab_pkg::ST_SUM_ACC;
         end
         alab_pkg::ST_SUM_ACC: begin
            sum_in = sum_ff + 24'(avg_rd_ff);
            if (idx_ff == fill_ff) begin
               num_in = DW'(sum_in);
               den_in = DW'(fill_ff);
               div_start = 1'b1;
               st_in = alab_pkg::ST_DIV;
            end else st_in = alab_pkg::ST_SUM_RD;
         end
         alab_pkg::ST_DIV: begin
            if (div_done) begin
               mean_in = div_q[15:0];
               if (div_q[15:0] < bot_ff) bot_in = div_q[15:0];
               st_in = cal_full ? alab_pkg::ST_IDLE : alab_pkg::ST_CAL_WR;
            end
         end
         alab_pkg::ST_CAL_WR: begin
            cal_we = 1'b1;
            ccnt_in = ccnt_ff + CW'(1);
            if (ccnt_ff == CW'(CAL_DEPTH - 1)) begin
               j_in = CA'(1); m_in = CA'(1); key_ok_in = 1'b0;
               st_in = alab_pkg::ST_SORT_RD;
            end else st_in = alab_pkg::ST_IDLE;
         end
         // insertion sort: key read from j, m walks down comparing m-1
         alab_pkg::ST_SORT_RD: begin
            if (!key_ok_ff) begin
               cal_ra = j_ff;
               st_in = alab_pkg::ST_SORT_CMP;
            end else if (m_ff == '0) begin
               // reached the bottom, key goes to entry 0
               cal_we = 1'b1; cal_wa = '0; cal_wd = key_ff;
               key_ok_in = 1'b0;
               if (j_ff == CA'(CAL_DEPTH - 1)) st_in = alab_pkg::ST_RANK_RD;
               else begin
                  j_in = j_ff + CA'(1);
                  st_in = alab_pkg::ST_SORT_RD;
               end
            end else begin
               cal_ra = m_ff - CA'(1);
               st_in = alab_pkg::ST_SORT_CMP;
            end
         end
         alab_pkg::ST_SORT_CMP: begin
            if (!key_ok_ff) begin
               key_in = cal_rd_ff; key_ok_in = 1'b1; m_in = j_ff;
               st_in = alab_pkg::ST_SORT_RD;
            end else if (cal_rd_ff > key_ff) begin
               // shift the larger entry up one place
               cal_we = 1'b1; cal_wa = m_ff; cal_wd = cal_rd_ff;
               m_in = m_ff - CA'(1);
               st_in = alab_pkg::ST_SORT_RD;
            end else begin
               cal_we = 1'b1; cal_wa = m_ff; cal_wd = key_ff;
               key_ok_in = 1'b0;
               if (j_ff == CA'(CAL_DEPTH - 1)) st_in = alab_pkg::ST_RANK_RD;
               else begin
                  j_in = j_ff + CA'(1);
                  st_in = alab_pkg::ST_SORT_RD;
               end
            end
         end
         alab_pkg::ST_RANK_RD: begin
            rk = (32'(rank_ff) > CAL_DEPTH - 1) ? 8'(CAL_DEPTH - 1) : rank_ff;
            cal_ra = CA'(rk);
            st_in = alab_pkg::ST_RANK_GET;
         end
         alab_pkg::ST_RANK_GET: begin
            top_in = cal_rd_ff;
            st_in = alab_pkg::ST_IDLE;
         end
         alab_pkg::ST_TICK_NUM: begin
            hi_w = cal_full ? {1'b0, top_ff} : '0;
            lo_w = cal_full ? {1'b0, bot_ff} : '0;
            msp  = (span_ff == '0) ? 17'd1 : {1'b0, span_ff};
            // signed compare in 18 bits
            d_w = {1'b0, hi_w} - {1'b0, lo_w};
            if ($signed(d_w) < $signed({1'b0, msp})) begin
               sp_w = msp;
               d_w = {1'b0, 17'(mean_ff)} - ({1'b0, hi_w} - {1'b0, msp});
            end else begin
               sp_w = 17'(d_w);
               d_w = {1'b0, 17'(mean_ff)} - {1'b0, lo_w};
            end
            cf = {1'b0, ceil_ff} - {1'b0, floor_ff};
            tneg_in = d_w[17] ^ cf[9];
            num_in = DW'((d_w[17] ? 18'(-d_w) : d_w) * (cf[9] ? 10'(-cf) : cf)) << 16;
            den_in = DW'(sp_w);
            st_in = alab_pkg::ST_TICK_DIV;
         end
         alab_pkg::ST_TICK_DIV: begin
            div_start = 1'b1;
            st_in = alab_pkg::ST_TICK_EASE;
         end
         alab_pkg::ST_TICK_EASE: begin
            if (div_done) begin
               // full-width goal, the quotient reaches about 2^42 on a narrow span
               gw = {25'd0, floor_ff, 16'h0};
               gw = tneg_ff ? gw - {2'b00, div_q} : gw + {2'b00, div_q};
               if ($signed(gw) < $signed({25'd0, floor_ff, 16'h0}))
                  gw = {25'd0, floor_ff, 16'h0};
               else if ($signed(gw) > $signed({25'd0, ceil_ff, 16'h0}))
                  gw = {25'd0, ceil_ff, 16'h0};
               goal_in = gw[24:0];
               tneg_in = 1'b0;
               st_in = alab_pkg::ST_TICK_OUT;
            end
         end
         alab_pkg::ST_TICK_OUT: begin
            ea = 42'(acc_ff) * 42'(17'h10000 - 17'(ease_ff));
            eb = 42'(goal_ff) * 42'(ease_ff);
            es = 43'(ea) + 43'(eb) + 43'd32768;
            acc_in = es[40:16];
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = {6'd0, cal_full, mean_ff, acc_in[24:16]};
               st_in = alab_pkg::ST_IDLE;
            end else acc_in = acc_ff;
         end
         default: st_in = alab_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      samp_ff <= samp_in; key_ff <= key_in; idx_ff <= idx_in; j_ff <= j_in;
      m_ff <= m_in; sum_ff <= sum_in; num_ff <= num_in; den_ff <= den_in;
      goal_ff <= goal_in; rd_ff <= rd_in;
      if (reset) begin
         st_ff <= alab_pkg::ST_IDLE; wpos_ff <= '0; fill_ff <= '0; mean_ff <= '0;
         top_ff <= '0; bot_ff <= 16'hffff; ccnt_ff <= '0; acc_ff <= 25'h1000000;
         tneg_ff <= 1'b0; rv_ff <= 1'b0; key_ok_ff <= 1'b0;
      end else begin
         st_ff <= st_in; wpos_ff <= wpos_in; fill_ff <= fill_in; mean_ff <= mean_in;
         top_ff <= top_in; bot_ff <= bot_in; ccnt_ff <= ccnt_in; acc_ff <= acc_in;
         tneg_ff <= tneg_in; rv_ff <= rv_in; key_ok_ff <= key_ok_in;
      end
   end
endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int RING_DEPTH  = 64;
   localparam int LOG_DEPTH   = 256;
   localparam int WATCH_LIMIT = 300000;   // covers the one-off calibration sort
   localparam int DRAIN_WAIT  = 400;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // block ports
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_data   = '0;

   ambient_light_auto_brightness_unit u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state: our own copy of the registers and the block state
   logic [8:0]  cfg_floor, cfg_ceiling;
   logic [15:0] cfg_span, cfg_ease;
   logic [7:0]  cfg_rank;
   logic [15:0] light_ring [RING_DEPTH];
   int          ring_pos, ring_fill;
   logic [15:0] mean_light;
   logic [15:0] cal_mem [LOG_DEPTH];
   int          cal_fill;
   logic [15:0] top_light, bottom_light;
   logic [24:0] level_q16;

   typedef struct packed {
      logic [8:0]  level;
      logic [15:0] light;
      logic        cal_done;
   } level_report_type;

   level_report_type pending_reports[$];
   int  fail_count  = 0;
   int  quiet_count = 0;
   bit  idle_on     = 1'b1;   // random gaps on both sides when set

   function automatic logic [8:0] tab_entry(input int k);
      case (k)
         0: return 9'd0;    1: return 9'd22;   2: return 9'd44;   3: return 9'd63;
         4: return 9'd82;   5: return 9'd100;  6: return 9'd118;  7: return 9'd134;
         8: return 9'd150;  9: return 9'd165;  10: return 9'd179; 11: return 9'd193;
         12: return 9'd207; 13: return 9'd220; 14: return 9'd232; 15: return 9'd244;
         default: return 9'd256;
      endcase
   endfunction

   // 4.12 log2 of a raw conversion
   function automatic logic [15:0] log2_of(input logic [15:0] raw);
      logic [15:0] v;
      logic [31:0] r;
      int k;
      logic [31:0] q;
      v = raw;
      r = 32'hc000;
      if ((v & 16'hf000) != 0) begin
         if ((v & 16'hc000) != 0) begin v = v >> 2; r += 32'h2000; end
         if ((v & 16'h2000) != 0) begin v = v >> 1; r += 32'h1000; end
      end else begin
         if ((v & 16'hffc0) == 0) begin v = v << 6; r -= 32'h6000; end
         if ((v & 16'hfe00) == 0) begin v = v << 3; r -= 32'h3000; end
         if ((v & 16'hf800) == 0) begin v = v << 2; r -= 32'h2000; end
         if ((v & 16'hf000) == 0) begin v = v << 1; r -= 32'h1000; end
      end
      k = int'(v[11:8]);
      q = {24'd0, v[7:0]};
      r += (tab_entry(k) * (256 - q) + tab_entry(k + 1) * q + 8) >> 4;
      return r[15:0];
   endfunction

   task automatic predict_reset();
      cfg_floor = 9'd64; cfg_ceiling = 9'd256; cfg_span = 16'd256; cfg_ease = 16'd655;
      cfg_rank = 8'd213;
      ring_pos = 0; ring_fill = 0; mean_light = '0;
      cal_fill = 0; top_light = '0; bottom_light = 16'hffff;
      level_q16 = 25'h1000000;
   endtask

   task automatic predict_sample(input logic [11:0] adc);
      longint sum;
      logic [15:0] key;
      int m;
      sum = 0;
      light_ring[ring_pos] = log2_of({4'h0, adc});
      ring_pos = (ring_pos + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
      for (int i = 0; i < ring_fill; i++) sum += light_ring[i];
      mean_light = 16'(sum / ring_fill);
      if (cal_fill < LOG_DEPTH) begin
         cal_mem[cal_fill] = mean_light;
         cal_fill++;
         if (cal_fill == LOG_DEPTH) begin
            for (int j = 1; j < LOG_DEPTH; j++) begin
               key = cal_mem[j];
               m = j;
               while (m > 0 && cal_mem[m - 1] > key) begin
                  cal_mem[m] = cal_mem[m - 1];
                  m--;
               end
               cal_mem[m] = key;
            end
            top_light = cal_mem[cfg_rank];   // 8-bit rank never passes the log
         end
      end
      if (mean_light < bottom_light) bottom_light = mean_light;
   endtask

   function automatic level_report_type predict_tick();
      longint lo, hi, span, goal, num, fl, ce, ms;
      longint unsigned acc;
      level_report_type rep;
      fl = cfg_floor;
      ce = cfg_ceiling;
      ms = (cfg_span == 0) ? 1 : cfg_span;
      if (cal_fill < LOG_DEPTH) begin lo = 0; hi = 0; end
      else begin lo = bottom_light; hi = top_light; end
      if (hi - lo < ms) lo = hi - ms;
      span = hi - lo;
      num = (longint'(mean_light) - lo) * (ce - fl) * 65536;
      goal = fl * 65536 + num / span;
      if (goal < fl * 65536) goal = fl * 65536;
      else if (goal > ce * 65536) goal = ce * 65536;
      acc = (longint'(level_q16) * (65536 - cfg_ease) + goal * cfg_ease + 32768) >> 16;
      level_q16 = acc[24:0];
      rep.level    = level_q16[24:16];
      rep.light    = mean_light;
      rep.cal_done = (cal_fill >= LOG_DEPTH);
      return rep;
   endfunction

   // send one word, predicting at acceptance; valid stays up until the next
   // word or a gap so that no signal gets two updates in one step
   task automatic send_word(input logic op, input logic [11:0] adc);
      csr_valid <= 1'b0;
      while (idle_on && $urandom_range(99) < 33) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'h0, adc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == alab_pkg::OP_SAMPLE) predict_sample(adc);
      else pending_reports.push_back(predict_tick());
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         alab_pkg::CSR_LEVEL_FLOOR:   cfg_floor   = val[8:0];
         alab_pkg::CSR_LEVEL_CEILING: cfg_ceiling = val[8:0];
         alab_pkg::CSR_MIN_SPAN:      cfg_span    = val;
         alab_pkg::CSR_EASE_COEFF:    cfg_ease    = val;
         alab_pkg::CSR_CEILING_RANK:  cfg_rank    = val[7:0];
         default: ;
      endcase
   endtask

   // wait until every report is in, then let a trailing sample finish
   task automatic drain();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // sample biased toward edges and bit extremes
   function automatic logic [11:0] pick_adc();
      case ($urandom_range(5))
         0: return 12'(1 << $urandom_range(11));
         1: return 12'($urandom_range(63));
         2: return 12'hfff - 12'($urandom_range(15));
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic run_mix(input int words, input int tick_pct);
      for (int i = 0; i < words; i++)
         if ($urandom_range(99) < tick_pct) send_word(alab_pkg::OP_TICK, 12'($urandom));
         else send_word(alab_pkg::OP_SAMPLE, pick_adc());
   endtask

   // ---- test tasks ----

   // extremes of the ADC and the log special cases before calibration
   task automatic test_directed_edges();
      send_word(alab_pkg::OP_TICK, '0);
      send_word(alab_pkg::OP_SAMPLE, 12'h000);   // log of zero
      send_word(alab_pkg::OP_TICK, 12'hfff);
      send_word(alab_pkg::OP_SAMPLE, 12'hfff);
      send_word(alab_pkg::OP_SAMPLE, 12'h001);
      send_word(alab_pkg::OP_SAMPLE, 12'h800);
      send_word(alab_pkg::OP_SAMPLE, 12'h040);
      send_word(alab_pkg::OP_SAMPLE, 12'h03f);
      send_word(alab_pkg::OP_SAMPLE, 12'h1ff);
      send_word(alab_pkg::OP_SAMPLE, 12'h200);
      send_word(alab_pkg::OP_SAMPLE, 12'h555);
      send_word(alab_pkg::OP_SAMPLE, 12'haaa);
      send_word(alab_pkg::OP_TICK, 12'h000);
      drain();
   endtask

   // every register, extremes included, before calibration completes
   task automatic test_config_extremes();
      write_reg(alab_pkg::CSR_EASE_COEFF, 16'hffff);
      write_reg(alab_pkg::CSR_MIN_SPAN, 16'h0000);      // zero span taken as one
      run_mix(10, 50);
      drain();
      write_reg(alab_pkg::CSR_LEVEL_FLOOR, 16'h01ff);   // floor above ceiling
      write_reg(alab_pkg::CSR_LEVEL_CEILING, 16'h0000);
      write_reg(alab_pkg::CSR_EASE_COEFF, 16'h0000);    // accumulator holds
      run_mix(8, 50);
      drain();
      write_reg(alab_pkg::CSR_EASE_COEFF, 16'h8000);
      run_mix(6, 50);
      drain();
      write_reg(alab_pkg::CSR_LEVEL_FLOOR, 16'h0000);
      write_reg(alab_pkg::CSR_LEVEL_CEILING, 16'h01ff);
      write_reg(alab_pkg::CSR_MIN_SPAN, 16'hffff);
      write_reg(alab_pkg::CSR_CEILING_RANK, 16'h00ff);  // rank at the end of the log
      drain();
   endtask

   // fill the calibration log with a slow light ramp and some noise
   task automatic test_calibration();
      write_reg(alab_pkg::CSR_MIN_SPAN, 16'd64);
      write_reg(alab_pkg::CSR_EASE_COEFF, 16'd12000);
      while (cal_fill < LOG_DEPTH) begin
         if ($urandom_range(99) < 20) send_word(alab_pkg::OP_TICK, '0);
         else send_word(alab_pkg::OP_SAMPLE, ($urandom_range(9) == 0) ? pick_adc()
                                  : 12'(cal_fill * 16 + $urandom_range(15)));
      end
      send_word(alab_pkg::OP_TICK, '0);
      drain();
   endtask

   // calibrated range, then late register changes including rank
   task automatic test_after_calibration();
      idle_on = 1'b0;                         // no gaps on either side
      run_mix(60, 40);
      drain();
      idle_on = 1'b1;
      write_reg(alab_pkg::CSR_CEILING_RANK, 16'h0000);  // no effect any more
      write_reg(alab_pkg::CSR_LEVEL_FLOOR, 16'd64);
      write_reg(alab_pkg::CSR_LEVEL_CEILING, 16'd256);
      write_reg(alab_pkg::CSR_MIN_SPAN, 16'd1);
      write_reg(alab_pkg::CSR_EASE_COEFF, 16'd655);
      run_mix(80, 40);
      drain();
      write_reg(alab_pkg::CSR_EASE_COEFF, 16'hffff);
      write_reg(alab_pkg::CSR_MIN_SPAN, 16'hffff);
      run_mix(60, 50);
      drain();
   endtask

   // ---- result side: random stall, compare each word ----
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !idle_on || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      level_report_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.level    = rsp_tdata[8:0];
         got.light    = rsp_tdata[24:9];
         got.cal_done = rsp_tdata[25];
         if (pending_reports.size() == 0) begin
            $display("%0t: result word with none expected, actual %h", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_reports.pop_front();
            if (got.level !== want.level) begin
               $display("%0t: level expected %0d actual %0d", $time, want.level, got.level);
               fail_count++;
            end
            if (got.light !== want.light) begin
               $display("%0t: light expected %h actual %h", $time, want.light, got.light);
               fail_count++;
            end
            if (got.cal_done !== want.cal_done) begin
               $display("%0t: calibrated expected %b actual %b", $time,
                        want.cal_done, got.cal_done);
               fail_count++;
            end
         end
      end
   end

   // watchdog: cycles with no word moving on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_count <= 0;
      else
         quiet_count <= quiet_count + 1;
      if (quiet_count >= WATCH_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      predict_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_config_extremes();
      test_calibration();
      test_after_calibration();
      drain();
      if (fail_count == 0 && pending_reports.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
sv/alab_pkg.sv
sv/alab_log2.sv
sv/alab_div.sv
sv/ambient_light_auto_brightness_unit.sv
verif/tb.sv
